[rtl/trial_division_prime_test_top_defines.svh]
// Assertion macros for the trial-division prime test block.
// Included by the top level; it expects a clock aclk and a reset aresetn.
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define TDPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define TDPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/tdpt_pkg.sv]
// Package for the trial-division prime test block.
// Holds the operand widths and the controller state type; depends on nothing.
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 2;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [DIV_WIDTH-1:0] DIV_TWO   = DIV_WIDTH'(2);
    localparam logic [DIV_WIDTH-1:0] DIV_THREE = DIV_WIDTH'(3);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST  = CNT_WIDTH'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_FINISH
    } tdpt_state_t;

endpackage

`default_nettype wire

[rtl/trial_division_prime_test_top.sv]
// Divisors 2, 3, 5, 7, ... are tried in turn; candidates 0 and 1 go straight to the result.
// Each trial runs the bit-serial restoring divider, one quotient bit a cycle, then a bound check.
// For a 31-bit prime near the top of the range that is about 23171 divisors.
// One transaction is in work at a time; a new one is taken while a result waits for m_ready.
// Reset (aresetn low at a rising edge) empties the block and drops any result not yet taken.
`default_nettype none

module trial_division_prime_test_top
    import tdpt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [VALUE_WIDTH-1:0] s_candidate,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_is_prime
);

`include "trial_division_prime_test_top_defines.svh"

    tdpt_state_t            state_reg, state_next;
    logic [VALUE_WIDTH-1:0] held_reg, held_next;
    logic [VALUE_WIDTH-1:0] work_reg, work_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]   div_reg, div_next;
    logic [CNT_WIDTH-1:0]   count_reg, count_next;
    logic                   prime_reg, prime_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;

    logic [DIV_WIDTH:0]     trial;
    logic                   qbit;
    logic                   below_bound;
    logic                   out_free;
    logic                   accept;

    assign accept      = s_valid && s_ready;
    assign out_free    = !out_valid_reg || m_ready;
    assign trial       = {rem_reg, work_reg[VALUE_WIDTH-1]};
    assign qbit        = (trial >= {1'b0, div_reg});
    assign below_bound = (work_reg < VALUE_WIDTH'(div_reg));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_candidate < VALUE_WIDTH'(2)) ? ST_FINISH : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (count_reg == CNT_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (below_bound || rem_reg == '0) ? ST_FINISH : ST_DIVIDE;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        held_next      = held_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        count_next     = count_reg;
        prime_next     = prime_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_prime_next = out_prime_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    held_next  = s_candidate;
                    work_next  = s_candidate;
                    rem_next   = '0;
                    div_next   = DIV_TWO;
                    count_next = '0;
                    prime_next = 1'b0;
                end
            end
            ST_DIVIDE: begin
                if (qbit) begin
                    rem_next = DIV_WIDTH'(trial - {1'b0, div_reg});
                end else begin
                    rem_next = trial[DIV_WIDTH-1:0];
                end
                work_next  = {work_reg[VALUE_WIDTH-2:0], qbit};
                count_next = count_reg + CNT_WIDTH'(1);
            end
            ST_CHECK: begin
                prime_next = below_bound;
                work_next  = held_reg;
                rem_next   = '0;
                count_next = '0;
                div_next   = (div_reg == DIV_TWO) ? DIV_THREE : div_reg + DIV_WIDTH'(2);
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg      <= held_next;
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        count_reg     <= count_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_is_prime = out_prime_reg;

    // The partial remainder always stays below the divisor.
    `TDPT_ASSERT(a_rem_below_div, (state_reg == ST_DIVIDE) |-> (rem_reg < div_reg), "remainder not below divisor")
    // Only two and odd numbers are ever tried as divisors.
    `TDPT_ASSERT(a_div_odd, (state_reg == ST_DIVIDE) |-> (div_reg[0] || div_reg == DIV_TWO), "even divisor above two")
    // A bound check always follows a complete division.
    `TDPT_ASSERT(a_check_after_div, (state_reg == ST_CHECK) |-> ($past(state_reg) == ST_DIVIDE && $past(count_reg) == CNT_LAST), "check without full division")
    // A new result appears only when a test has finished.
    `TDPT_ASSERT(a_result_from_finish, $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH), "result without finished test")
    // Reset leaves no result pending.
    `TDPT_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !out_valid_reg, "result pending after reset")

endmodule

`default_nettype wire
